// ----- hdl/fps_pkg.sv -----
// Package for the fixed-point sine and cosine pipeline.
// Holds field widths, polynomial coefficients and shift amounts.
// No dependencies.
package fps_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned ValueW = 14;
  localparam int unsigned XW     = 14;
  localparam int unsigned AccW   = 32;
  localparam int unsigned ShN    = 13;
  localparam int unsigned ShR    = 3;
  localparam int unsigned ShQ    = 31;
  localparam int unsigned ShOut  = 12;
  localparam int unsigned TW     = AccW - ShN;
  localparam int unsigned MagW   = AccW - (ShQ - ShOut);

  localparam logic [AccW-1:0]   CoefA   = 32'd3370945099;
  localparam logic [AccW-1:0]   CoefB   = 32'd2746362156;
  localparam logic [AccW-1:0]   CoefC   = 32'd292421;
  localparam logic [AngleW-1:0] Quarter = 16'd8192;
  localparam logic [AngleW-1:0] HalfPt  = 16'h8000;
  localparam logic [AccW-1:0]   RoundK  = AccW'(1) << (ShQ - ShOut - 1);

  localparam logic signed [ValueW-1:0] ValueMax = 14'sd4096;
  localparam logic signed [ValueW-1:0] ValueMin = -14'sd4096;

endpackage

// ----- hdl/fixed_point_sine_cosine_top.sv -----
// Pipelined fixed-point sine/cosine: throughput one transaction per cycle while
// the output is not stalled.
// Seven register stages: quadrant fold, five multiplier stages, round/negate.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
// Depends on fps_pkg.
module fixed_point_sine_cosine_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [fps_pkg::AngleW-1:0]    angle_i,
  input  logic                                 action_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fps_pkg::ValueW-1:0]    value_o
);
  import fps_pkg::*;

  localparam int unsigned NStg = 7;

  logic                 adv;
  logic [NStg-1:0]      v_q, v_d;
  logic [XW-1:0]        x_q [NStg-1];
  logic                 n_q [NStg-1];
  logic [AccW-1:0]      m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [AccW-1:0]      m1_d, m2_d, m3_d, m4_d, m5_d;
  logic [ValueW-1:0]    val_q, val_d;

  logic [AngleW-1:0]    ang, dbl;
  logic [XW-1:0]        x_d;
  logic [AccW-1:0]      a3, a5, rnd;
  logic [MagW-1:0]      mag;
  logic [AccW:0]        p1, p2, p3, p4, p5;

  assign adv        = !v_q[NStg-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    ang = action_i ? AngleW'(angle_i) + Quarter : AngleW'(angle_i);
    dbl = {ang[AngleW-2:0], 1'b0};
    if (ang[13]) begin
      dbl = HalfPt - dbl;
    end
    x_d = dbl[XW:1];
  end

  always_comb begin
    p1   = {1'b0, CoefC} * {{(AccW+1-XW){1'b0}}, x_q[0]};
    m1_d = p1[AccW-1:0];
    p2   = {{(AccW+1-XW){1'b0}}, x_q[1]} * {{(AccW+1-TW){1'b0}}, m1_q[AccW-1:ShN]};
    m2_d = p2[AccW-1:0];
    a3   = CoefB - {{ShR{1'b0}}, m2_q[AccW-1:ShR]};
    p3   = {{(AccW+1-XW){1'b0}}, x_q[2]} * {{(AccW+1-TW){1'b0}}, a3[AccW-1:ShN]};
    m3_d = p3[AccW-1:0];
    p4   = {{(AccW+1-XW){1'b0}}, x_q[3]} * {{(AccW+1-TW){1'b0}}, m3_q[AccW-1:ShN]};
    m4_d = p4[AccW-1:0];
    a5   = CoefA - {1'b0, m4_q[AccW-1:1]};
    p5   = {{(AccW+1-XW){1'b0}}, x_q[4]} * {{(AccW+1-TW){1'b0}}, a5[AccW-1:ShN]};
    m5_d = p5[AccW-1:0];
    rnd  = m5_q + RoundK;
    mag  = rnd[AccW-1:ShQ-ShOut];
    val_d = n_q[5] ? ValueW'(0) - {1'b0, mag} : {1'b0, mag};
  end

  always_comb begin
    v_d = {v_q[NStg-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= x_d;
      n_q[0] <= ang[14];
      for (int i = 1; i < NStg - 1; i++) begin
        x_q[i] <= x_q[i-1];
        n_q[i] <= n_q[i-1];
      end
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      m3_q  <= m3_d;
      m4_q  <= m4_d;
      m5_q  <= m5_d;
      val_q <= val_d;
    end
  end

  assign out_valid_o = v_q[NStg-1];
  assign value_o     = signed'(val_q);

endmodule

// ----- hdl/fps_checker.sv -----
// Port-level checker for fixed_point_sine_cosine_top, bound to the top level.
// Depends on fps_pkg.
module fps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [fps_pkg::AngleW-1:0] angle_i,
  input logic                              action_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [fps_pkg::ValueW-1:0] value_o
);
  import fps_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(angle_i) && $stable(action_i))
    else $error("input transaction changed while stalled");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o))
    else $error("output transaction changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output backpressure");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o >= ValueMin) && (value_o <= ValueMax))
    else $error("result out of range");

endmodule

bind fixed_point_sine_cosine_top fps_checker u_fps_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for fixed_point_sine_cosine_top: corner angles, random angles under
// mixed idling on both sides and a long output stall, each result checked against a local model.
// Depends on fps_pkg and the fixed_point_sine_cosine_top RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fps_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StallCycles = 60;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [AngleW-1:0] angle_i;
  logic                     action_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [ValueW-1:0] value_o;

  logic signed [ValueW-1:0] expected_values[$];
  logic signed [ValueW-1:0] expected_value;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  int unsigned hold_left;
  bit          hold_armed;

  fixed_point_sine_cosine_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .angle_i    (angle_i),
    .action_i   (action_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

  function automatic logic signed [ValueW-1:0] sine_cosine_of(input logic [AngleW-1:0] angle,
                                                              input logic action);
    logic [AngleW-1:0] turned;
    logic [AngleW-1:0] doubled;
    logic              lower_half;
    logic [AccW-1:0]   x;
    logic [AccW-1:0]   acc;
    turned = action ? angle + Quarter : angle;
    doubled = {turned[AngleW-2:0], 1'b0};
    lower_half = doubled[AngleW-1];
    if (doubled[AngleW-2]) begin
      doubled = HalfPt - doubled;
    end
    x = AccW'(doubled[AngleW-2:1]);
    acc = (CoefC * x) >> ShN;
    acc = CoefB - ((x * acc) >> ShR);
    acc = x * (acc >> ShN);
    acc = x * (acc >> ShN);
    acc = CoefA - (acc >> (AccW - ShQ));
    acc = x * (acc >> ShN);
    acc = (acc + RoundK) >> (ShQ - ShOut);
    if (lower_half) begin
      acc = -acc;
    end
    return acc[ValueW-1:0];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_values.size() == 0) begin
          $error("value: no transaction pending, actual %0d", value_o);
          error_count++;
        end else begin
          expected_value = expected_values.pop_front();
          checked_count++;
          if (value_o !== expected_value) begin
            $error("value mismatch: expected %0d, actual %0d", expected_value, value_o);
            error_count++;
          end
        end
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  task automatic send_angle(input logic [AngleW-1:0] angle, input logic action);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    angle_i    <= angle;
    action_i   <= action;
    do @(posedge clk_i); while (!in_ready_o);
    expected_values.push_back(sine_cosine_of(angle, action));
    sent_count++;
  endtask

  task automatic test_corner_angles();
    logic [AngleW-1:0] corners[12];
    corners = '{16'h0000, 16'h0001, 16'h1FFF, 16'h2000, 16'h2001, 16'h3FFF,
                16'h4000, 16'h6000, 16'h7FFF, 16'h8000, 16'hA000, 16'hFFFF};
    send_gap_pct = 0;
    recv_gap_pct = 0;
    foreach (corners[i]) begin
      send_angle(corners[i], 1'b0);
      send_angle(corners[i], 1'b1);
    end
  endtask

  task automatic test_random_angles(input int unsigned count, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    repeat (count) begin
      send_angle(AngleW'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_output_stall();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_armed = 1'b1;
    repeat (40) begin
      send_angle(AngleW'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    recv_gap_pct = 0;
    while (expected_values.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    angle_i = '0;
    action_i = 1'b0;
    hold_armed = 1'b0;
    hold_left = 0;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_angles();
    test_random_angles(380, 8, 64);
    test_random_angles(380, 64, 8);
    test_random_angles(330, 0, 0);
    test_output_stall();
    drain_results();

    $display("Sent %0d sine and cosine transactions: quadrant corners, random angles", sent_count);
    $display("under three idle mixes and a %0d-cycle output stall; %0d results checked.",
             StallCycles, checked_count);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- fixed_point_sine_cosine_top.f -----
hdl/fps_pkg.sv
hdl/fixed_point_sine_cosine_top.sv
hdl/fps_checker.sv
dv/testbench.sv
